/* rtl/u8d_pkg.sv */
`default_nettype none

package u8d_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_SEQ  = 2'd2;
  localparam logic [1:0] ST_NOT_UCS2 = 2'd3;

  // Configuration register indexes.
  localparam logic REG_UCS2_MODE  = 1'b0;
  localparam logic REG_CHAR_LIMIT = 1'b1;

  localparam logic [31:0] CHAR_LIMIT_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  bytes_left;
    logic [30:0] value_acc;
    logic [7:0]  lead_byte;
    logic [7:0]  first_follow;
    logic        follow_ok;
    logic [31:0] chars_done;
    logic        stopped;
  } u8d_state_t;

  // Decode state after reset: everything clear except follow_ok.
  localparam u8d_state_t STATE_RESET =
    u8d_state_t'({3'd0, 31'd0, 8'd0, 8'd0, 1'b1, 32'd0, 1'b0});

  typedef struct packed {
    logic        valid;
    logic [30:0] code_point;
    logic [1:0]  status;
  } u8d_result_t;

  // Continuation bytes called for by a valid lead byte.
  function automatic logic [2:0] follow_count(input logic [7:0] lead);
    logic [2:0] n;
    if (lead < 8'hE0)      n = 3'd1;
    else if (lead < 8'hF0) n = 3'd2;
    else if (lead < 8'hF8) n = 3'd3;
    else if (lead < 8'hFC) n = 3'd4;
    else                   n = 3'd5;
    return n;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] n);
    logic [7:0] m;
    unique case (n)
      3'd1:    m = 8'h1F;
      3'd2:    m = 8'h0F;
      3'd3:    m = 8'h07;
      3'd4:    m = 8'h03;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  function automatic logic not_overlong(input logic [7:0] lead, input logic [7:0] first);
    logic ok;
    unique case (lead)
      8'hE0:   ok = (first >= 8'hA0);
      8'hF0:   ok = (first >= 8'h90);
      8'hF8:   ok = (first >= 8'h88);
      8'hFC:   ok = (first >= 8'h84);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

/* rtl/u8d_step.sv */
`default_nettype none

module u8d_step (
  input  u8d_pkg::u8d_state_t  state,
  input  logic [7:0]           in_byte,
  input  logic                 ucs2_mode,
  input  logic [31:0]          char_limit,
  output u8d_pkg::u8d_state_t  state_next,
  output u8d_pkg::u8d_result_t result
);
  import u8d_pkg::*;

  logic        do_emit;
  logic        do_err;
  logic [1:0]  err_code;
  logic [30:0] emit_cp;
  logic [30:0] acc_shift;
  logic [2:0]  left_dec;
  logic        follow_ok_now;
  logic [7:0]  first_now;
  logic [2:0]  n_lead;
  logic [31:0] done_inc;

  assign n_lead    = follow_count(in_byte);
  assign acc_shift = {state.value_acc[24:0], in_byte[5:0]};
  assign left_dec  = state.bytes_left - 3'd1;
  assign first_now = (state.bytes_left == follow_count(state.lead_byte)) ?
                     in_byte : state.first_follow;
  assign follow_ok_now = state.follow_ok & (in_byte[7:6] == 2'b10);
  assign done_inc  = state.chars_done + 32'd1;

  always_comb begin
    state_next = state;
    do_emit    = 1'b0;
    do_err     = 1'b0;
    err_code   = ST_OK;
    emit_cp    = '0;
    result     = '0;

    if (state.stopped) begin
      // drop the byte
    end else if (state.chars_done >= char_limit) begin
      state_next.stopped = 1'b1;
    end else if (state.bytes_left == 3'd0) begin
      if (in_byte < 8'h80) begin
        do_emit = 1'b1;
        emit_cp = {23'd0, in_byte};
      end else if (in_byte < 8'hC2 || in_byte >= 8'hFE) begin
        do_err   = 1'b1;
        err_code = ST_BAD_LEAD;
      end else begin
        state_next.lead_byte    = in_byte;
        state_next.value_acc    = {23'd0, in_byte & lead_mask(n_lead)};
        state_next.first_follow = 8'd0;
        state_next.follow_ok    = 1'b1;
        state_next.bytes_left   = n_lead;
      end
    end else begin
      state_next.first_follow = first_now;
      state_next.follow_ok    = follow_ok_now;
      state_next.value_acc    = acc_shift;
      state_next.bytes_left   = left_dec;
      if (left_dec == 3'd0) begin
        state_next.follow_ok = 1'b1;
        if (!follow_ok_now || !not_overlong(state.lead_byte, first_now)) begin
          do_err   = 1'b1;
          err_code = ST_BAD_SEQ;
        end else begin
          do_emit = 1'b1;
          emit_cp = acc_shift;
        end
      end
    end

    // UCS-2 range check on an emitted character
    if (do_emit && ucs2_mode &&
        (emit_cp >= 31'h10000 || (emit_cp >= 31'hD800 && emit_cp < 31'hE000))) begin
      do_emit  = 1'b0;
      do_err   = 1'b1;
      err_code = ST_NOT_UCS2;
    end

    if (do_err) begin
      result.valid       = 1'b1;
      result.status      = err_code;
      state_next.stopped = 1'b1;
    end else if (do_emit) begin
      result.valid          = 1'b1;
      result.code_point     = emit_cp;
      result.status         = ST_OK;
      state_next.chars_done = done_inc;
      if (done_inc >= char_limit) state_next.stopped = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8_stream_decoder_core.sv */
`default_nettype none

// UTF-8 stream decoder, original six-byte form, code points up to 31 bits.
//
// Input stream (s_*): one raw byte per beat in s_tdata.
// Output stream (m_*): at most one result per input byte. m_tdata carries the
// code point (zero on error), m_tuser the status: ok, bad lead byte, bad or
// overlong sequence, or outside UCS-2 range.
// Config port (cfg_*): index 0 writes ucs2_mode, index 1 writes char_limit.
// Always ready; write only while the block is idle.
//
// A byte accepted into the input register feeds one level of decode logic
// into the output register. Throughput is one byte per clock: a byte advances
// whenever the output register is empty or being drained in the same cycle.
// When the receiver stalls, the output register holds and the input register
// fills; s_tready then drops until m_tready returns.
//
// Reset (rst, synchronous) empties both registers, clears the decode state
// and returns ucs2_mode to 0 and char_limit to all ones. After an error
// result or once char_limit characters are out, bytes are taken and dropped
// until the next reset.

module utf8_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte in: [7:0] in_byte
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // result out: tdata [30:0] code_point, [31] zero; tuser [1:0] status
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  output logic [1:0]       m_tuser,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import u8d_pkg::*;

  logic        ucs2_mode;
  logic [31:0] char_limit;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;

  u8d_state_t  state;
  u8d_state_t  state_next;
  u8d_result_t result;

  logic        out_valid;
  logic [30:0] out_cp;
  logic [1:0]  out_status;

  // Move a byte through decode when the output slot is free this cycle.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_cp};
  assign m_tuser  = out_status;

  u8d_step u_step (
    .state      (state),
    .in_byte    (in_byte),
    .ucs2_mode  (ucs2_mode),
    .char_limit (char_limit),
    .state_next (state_next),
    .result     (result)
  );

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ucs2_mode  <= 1'b0;
      char_limit <= CHAR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UCS2_MODE:  ucs2_mode  <= cfg_data[0];
        REG_CHAR_LIMIT: char_limit <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Input register: load on accepted beat, empty when the byte is decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  // Decode state: advance once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register: fill with a result, drain on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_cp     <= result.code_point;
      out_status <= result.status;
    end
  end

  // Error results carry a zero code point.
  a_err_zero_cp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 32'd0))
    else $error("error result with nonzero code point");

  // Once stopped, stay stopped until reset.
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    state.stopped |=> state.stopped)
    else $error("decoder left stopped state without reset");

  // Never more than five continuation bytes pending.
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    state.bytes_left <= 3'd5)
    else $error("bytes_left out of range");

  // An ok result counts exactly one character.
  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    (advance && result.valid && result.status == ST_OK) |=>
      (state.chars_done == $past(state.chars_done) + 32'd1))
    else $error("character count did not advance on ok result");

  // A stopped block produces no results.
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && state.stopped) |-> !result.valid)
    else $error("result produced while stopped");

endmodule

`default_nettype wire
